### rtl/core/tcr_pkg.sv
package tcr_pkg;

  localparam int GLYPH_WIDTH_DEF  = 5;
  localparam int GLYPH_HEIGHT_DEF = 8;
  localparam int SCREEN_SIZE_DEF  = 128;

  // Printable range; one glyph per code from first to last
  localparam int GLYPH_COUNT = 96;
  localparam logic [7:0] CHAR_FIRST = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7f;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;

  localparam logic OP_PRINT = 1'b0;
  localparam logic OP_FONT  = 1'b1;

  localparam logic REG_FOREGROUND = 1'b0;
  localparam logic REG_BACKGROUND = 1'b1;

  localparam logic [15:0] FOREGROUND_RESET = 16'hffff;
  localparam logic [15:0] BACKGROUND_RESET = 16'h0000;

  localparam logic [1:0] KIND_WINDOW = 2'd0;
  localparam logic [1:0] KIND_PIXELS = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_DISP  = 3'd1;
  localparam step_t STEP_GWIN  = 3'd2;
  localparam step_t STEP_PIX   = 3'd3;
  localparam step_t STEP_BCHK  = 3'd4;
  localparam step_t STEP_BWIN  = 3'd5;
  localparam step_t STEP_BRUN  = 3'd6;
  localparam step_t STEP_SLINE = 3'd7;

  typedef enum logic [2:0] {
    EMIT_NONE  = 3'd0,
    EMIT_GWIN  = 3'd1,
    EMIT_PIXEL = 3'd2,
    EMIT_BWIN  = 3'd3,
    EMIT_BRUN  = 3'd4,
    EMIT_SLINE = 3'd5
  } emit_t;

  typedef enum logic [2:0] {
    JMP_NEXT       = 3'd0,
    JMP_WAIT_PRINT = 3'd1,
    JMP_NOT_GLYPH  = 3'd2,
    JMP_PIX_MORE   = 3'd3,
    JMP_NOT_BAND   = 3'd4,
    JMP_ALWAYS     = 3'd5
  } cond_t;

  typedef struct packed {
    emit_t emit;
    cond_t cond;
    step_t target;
  } ucode_t;

  // Control store, indexed by step
  localparam ucode_t UCODE [8] = '{
    '{emit: EMIT_NONE,  cond: JMP_WAIT_PRINT, target: STEP_DISP},
    '{emit: EMIT_NONE,  cond: JMP_NOT_GLYPH,  target: STEP_BCHK},
    '{emit: EMIT_GWIN,  cond: JMP_NEXT,       target: STEP_IDLE},
    '{emit: EMIT_PIXEL, cond: JMP_PIX_MORE,   target: STEP_PIX},
    '{emit: EMIT_NONE,  cond: JMP_NOT_BAND,   target: STEP_IDLE},
    '{emit: EMIT_BWIN,  cond: JMP_NEXT,       target: STEP_IDLE},
    '{emit: EMIT_BRUN,  cond: JMP_NEXT,       target: STEP_IDLE},
    '{emit: EMIT_SLINE, cond: JMP_ALWAYS,     target: STEP_IDLE}
  };

endpackage

### rtl/core/text_console_renderer_top.sv
// Print request: after acceptance the sequencer passes a dispatch step, then for a glyph emits
// its window and its pixels, one result a cycle while the output is taken; a check step lies
// between the last pixel and a band clear. A glyph with a band clear gives 1 + W*H + 3 (44).
// A request holds the sequencer until its last result is loaded; font writes do not hold it.
// Reset (rst, synchronous): cursor, scroll flag, start line, colours and sequencer return
// to their defaults; the font memory is not cleared.
module text_console_renderer_top #(
  parameter int GLYPH_WIDTH  = tcr_pkg::GLYPH_WIDTH_DEF,
  parameter int GLYPH_HEIGHT = tcr_pkg::GLYPH_HEIGHT_DEF,
  parameter int SCREEN_SIZE  = tcr_pkg::SCREEN_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // char_code, font_address, font_byte
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // x_first, y_first, x_final, y_final, colour,
                                     // run_length, start_line
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast,  // last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int FONT_DEPTH = tcr_pkg::GLYPH_COUNT * GLYPH_WIDTH;
  localparam int FA_W  = $clog2(FONT_DEPTH);
  localparam int COL_W = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
  localparam int ROW_W = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

  logic [7:0] in_char;
  logic [8:0] in_addr;
  logic [7:0] in_byte;
  logic       in_fire;

  assign in_char = s_axis_tdata[7:0];
  assign in_addr = s_axis_tdata[16:8];
  assign in_byte = s_axis_tdata[24:17];
  assign in_fire = s_axis_tvalid && s_axis_tready;

  logic [15:0] fg_colour;
  logic [15:0] bg_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_colour <= tcr_pkg::FOREGROUND_RESET;
      bg_colour <= tcr_pkg::BACKGROUND_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tcr_pkg::REG_FOREGROUND) begin
        fg_colour <= cfg_data;
      end else begin
        bg_colour <= cfg_data;
      end
    end
  end

  // Sequencer
  tcr_pkg::step_t  step;
  tcr_pkg::step_t  step_next;
  tcr_pkg::ucode_t cw;
  logic            emitting;
  logic            stall;
  logic            glyph;
  logic            band;
  logic            pix_more;

  logic             out_valid;
  logic [1:0]       out_kind;
  logic [71:0]      out_data;
  logic             out_last;

  assign cw       = tcr_pkg::UCODE[step];
  assign emitting = (cw.emit != tcr_pkg::EMIT_NONE);
  assign stall    = emitting && out_valid && !m_axis_tready;
  assign s_axis_tready = (step == tcr_pkg::STEP_IDLE);

  always_comb begin
    step_next = step + 3'd1;
    case (cw.cond)
      tcr_pkg::JMP_NEXT:       step_next = step + 3'd1;
      tcr_pkg::JMP_WAIT_PRINT: step_next = (in_fire && s_axis_tuser == tcr_pkg::OP_PRINT)
                                           ? cw.target : step;
      tcr_pkg::JMP_NOT_GLYPH:  step_next = glyph ? step + 3'd1 : cw.target;
      tcr_pkg::JMP_PIX_MORE:   step_next = pix_more ? cw.target : step + 3'd1;
      tcr_pkg::JMP_NOT_BAND:   step_next = band ? step + 3'd1 : cw.target;
      tcr_pkg::JMP_ALWAYS:     step_next = cw.target;
      default:                 step_next = tcr_pkg::STEP_IDLE;
    endcase
    if (stall) begin
      step_next = step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= tcr_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Cursor update, worked out when a print request is taken
  logic [7:0] cursor_col;
  logic [7:0] cursor_row;
  logic       scroll_active;
  logic [6:0] display_start;

  logic [7:0] col_upd;
  logic [7:0] row_upd;
  logic       scroll_upd;
  logic       glyph_upd;
  logic       band_upd;
  logic [7:0] code_clamped;
  logic [7:0] start_sum;
  logic [6:0] start_upd;

  always_comb begin
    glyph_upd  = (in_char != tcr_pkg::CHAR_CR) && (in_char != tcr_pkg::CHAR_LF);
    col_upd    = cursor_col;
    row_upd    = cursor_row;
    scroll_upd = scroll_active;
    if (in_char == tcr_pkg::CHAR_CR) begin
      col_upd = 8'd0;
    end else if (in_char == tcr_pkg::CHAR_LF) begin
      row_upd = cursor_row + 8'(GLYPH_HEIGHT);
    end else begin
      col_upd = cursor_col + 8'(GLYPH_WIDTH);
    end
    if ({1'b0, col_upd} >= 9'(SCREEN_SIZE)) begin
      col_upd = 8'd0;
      row_upd = row_upd + 8'(GLYPH_HEIGHT);
    end
    if ({1'b0, row_upd} >= 9'(SCREEN_SIZE)) begin
      scroll_upd = 1'b1;
      row_upd    = 8'd0;
    end
    band_upd = scroll_upd && (row_upd != cursor_row);

    start_sum = {1'b0, display_start} + 8'(GLYPH_HEIGHT);
    start_upd = ({1'b0, start_sum} >= 9'(SCREEN_SIZE)) ? 7'd0 : start_sum[6:0];

    code_clamped = (in_char < tcr_pkg::CHAR_FIRST || in_char > tcr_pkg::CHAR_LAST)
                   ? tcr_pkg::CHAR_FIRST : in_char;
  end

  logic            print_fire;
  logic [7:0]      org_x;
  logic [7:0]      org_y;
  logic [FA_W-1:0] base;
  logic [7:0]      glyph_index;

  assign print_fire  = in_fire && (s_axis_tuser == tcr_pkg::OP_PRINT);
  assign glyph_index = code_clamped - tcr_pkg::CHAR_FIRST;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col    <= 8'd0;
      cursor_row    <= 8'd0;
      scroll_active <= 1'b0;
      display_start <= 7'd0;
      glyph         <= 1'b0;
      band          <= 1'b0;
    end else if (print_fire) begin
      cursor_col    <= col_upd;
      cursor_row    <= row_upd;
      scroll_active <= scroll_upd;
      glyph         <= glyph_upd;
      band          <= band_upd;
      if (band_upd) begin
        display_start <= start_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (print_fire) begin
      org_x <= cursor_col;
      org_y <= cursor_row;
      base  <= FA_W'(glyph_index) * FA_W'(GLYPH_WIDTH);
    end
  end

  // Pixel walk: the font read address follows the next column count, so the read matches the emitted pixel
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] col_cnt_next;
  logic [ROW_W-1:0] row_cnt_next;
  logic             pix_step;

  assign pix_more = !((row_cnt == ROW_W'(GLYPH_HEIGHT - 1)) &&
                      (col_cnt == COL_W'(GLYPH_WIDTH - 1)));
  assign pix_step = (cw.emit == tcr_pkg::EMIT_PIXEL) && !stall;

  always_comb begin
    col_cnt_next = col_cnt;
    row_cnt_next = row_cnt;
    if (print_fire) begin
      col_cnt_next = '0;
      row_cnt_next = '0;
    end else if (pix_step) begin
      if (col_cnt == COL_W'(GLYPH_WIDTH - 1)) begin
        col_cnt_next = '0;
        row_cnt_next = row_cnt + ROW_W'(1);
      end else begin
        col_cnt_next = col_cnt + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  logic            font_we;
  logic [FA_W-1:0] font_raddr;
  logic [7:0]      font_rdata;

  assign font_we = in_fire && (s_axis_tuser == tcr_pkg::OP_FONT) &&
                   (10'(in_addr) < 10'(FONT_DEPTH));
  assign font_raddr = base + FA_W'(col_cnt_next);

  tcr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (font_we),
    .waddr (FA_W'(in_addr)),
    .wdata (in_byte),
    .raddr (font_raddr),
    .rdata (font_rdata)
  );

  // Result assembly
  logic [1:0]  res_kind;
  logic [7:0]  res_x_first;
  logic [7:0]  res_y_first;
  logic [7:0]  res_x_final;
  logic [7:0]  res_y_final;
  logic [15:0] res_colour;
  logic [10:0] res_run;
  logic [6:0]  res_start;
  logic        res_last;

  always_comb begin
    res_kind    = tcr_pkg::KIND_WINDOW;
    res_x_first = 8'd0;
    res_y_first = 8'd0;
    res_x_final = 8'd0;
    res_y_final = 8'd0;
    res_colour  = 16'd0;
    res_run     = 11'd0;
    res_start   = 7'd0;
    res_last    = 1'b0;
    case (cw.emit)
      tcr_pkg::EMIT_GWIN: begin
        res_x_first = org_x;
        res_y_first = org_y;
        res_x_final = org_x + 8'(GLYPH_WIDTH - 1);
        res_y_final = org_y + 8'(GLYPH_HEIGHT - 1);
      end
      tcr_pkg::EMIT_PIXEL: begin
        res_kind   = tcr_pkg::KIND_PIXELS;
        res_colour = font_rdata[row_cnt] ? fg_colour : bg_colour;
        res_run    = 11'd1;
        res_last   = !pix_more && !band;
      end
      tcr_pkg::EMIT_BWIN: begin
        res_y_first = cursor_row;
        res_x_final = 8'(SCREEN_SIZE - 1);
        res_y_final = cursor_row + 8'(GLYPH_HEIGHT - 1);
      end
      tcr_pkg::EMIT_BRUN: begin
        res_kind   = tcr_pkg::KIND_PIXELS;
        res_colour = bg_colour;
        res_run    = 11'(SCREEN_SIZE * GLYPH_HEIGHT);
      end
      tcr_pkg::EMIT_SLINE: begin
        res_kind  = tcr_pkg::KIND_START;
        res_start = display_start;
        res_last  = 1'b1;
      end
      default: begin
        res_kind = tcr_pkg::KIND_WINDOW;
      end
    endcase
  end

  logic load;

  assign load = emitting && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= res_kind;
      out_last <= res_last;
      out_data <= {6'd0, res_start, res_run, res_colour,
                   res_y_final, res_x_final, res_y_first, res_x_first};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  a_window_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tlast && m_axis_tuser == tcr_pkg::KIND_WINDOW))
    else $error("window result marked last");

  a_start_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == tcr_pkg::KIND_START) |-> m_axis_tlast)
    else $error("start line result not last");

  a_font_in_range: assert property (@(posedge clk) disable iff (rst)
    (step == tcr_pkg::STEP_PIX) |-> (11'(base) + 11'(col_cnt) < 11'(FONT_DEPTH)))
    else $error("font read beyond memory");

  a_hold_when_busy: assert property (@(posedge clk) disable iff (rst)
    (step != tcr_pkg::STEP_IDLE) |=> ($stable(cursor_row) && $stable(display_start)))
    else $error("cursor moved during a print");
`endif

endmodule

### rtl/core/tcr_ram.sv
module tcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 480
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/sv/text_console_renderer_top_tb.sv
`timescale 1ns / 1ps

module text_console_renderer_top_tb;
  import tcr_pkg::*;

  localparam int GW            = GLYPH_WIDTH_DEF;
  localparam int GH            = GLYPH_HEIGHT_DEF;
  localparam int SCREEN        = SCREEN_SIZE_DEF;
  localparam int FONT_DEPTH    = GLYPH_COUNT * GW;
  localparam int LOADED_GLYPHS = 34;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE        = 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  x_first;
    logic [7:0]  y_first;
    logic [7:0]  x_final;
    logic [7:0]  y_final;
    logic [15:0] colour;
    logic [10:0] run_length;
    logic [6:0]  start_line;
    logic        last;
  } console_cmd_t;

  class console_scoreboard;
    logic [15:0]  fg;
    logic [15:0]  bg;
    logic [7:0]   col;
    logic [7:0]   row;
    logic         scrolling;
    logic [6:0]   start_line;
    logic [7:0]   font [FONT_DEPTH];
    console_cmd_t pending_cmds [$];
    int           failures;

    function new();
      fg         = FOREGROUND_RESET;
      bg         = BACKGROUND_RESET;
      col        = '0;
      row        = '0;
      scrolling  = 1'b0;
      start_line = '0;
      failures   = 0;
    endfunction

    function void set_colour(logic index, logic [15:0] value);
      if (index == REG_FOREGROUND) fg = value;
      else bg = value;
    endfunction

    // Work out the commands one accepted request draws and queue them
    function void note_request(logic op, logic [7:0] code, logic [8:0] addr,
                               logic [7:0] fbyte);
      console_cmd_t batch [$];
      console_cmd_t cmd;
      logic [7:0]   prev_row;
      logic [7:0]   glyph;
      logic [7:0]   bits;
      int           base;
      int           next_start;
      if (op == OP_FONT) begin
        if (addr < FONT_DEPTH) font[addr] = fbyte;
        return;
      end
      prev_row = row;
      if (code == CHAR_CR) begin
        col = '0;
      end else if (code == CHAR_LF) begin
        row = row + 8'(GH);
      end else begin
        glyph = (code < CHAR_FIRST || code > CHAR_LAST) ? CHAR_FIRST : code;
        base  = (int'(glyph) - int'(CHAR_FIRST)) * GW;
        cmd = '0;
        cmd.kind    = KIND_WINDOW;
        cmd.x_first = col;
        cmd.y_first = row;
        cmd.x_final = col + 8'(GW - 1);
        cmd.y_final = row + 8'(GH - 1);
        batch.push_back(cmd);
        for (int r = 0; r < GH; r++) begin
          for (int c = 0; c < GW; c++) begin
            bits = font[base + c];
            cmd = '0;
            cmd.kind       = KIND_PIXELS;
            cmd.colour     = bits[r] ? fg : bg;
            cmd.run_length = 11'd1;
            batch.push_back(cmd);
          end
        end
        col = col + 8'(GW);
      end
      if (col >= SCREEN) begin
        col = '0;
        row = row + 8'(GH);
      end
      if (row >= SCREEN) begin
        scrolling = 1'b1;
        row = '0;
      end
      // Once scrolling, every row change wipes the new band and moves the start line
      if (scrolling && prev_row != row) begin
        cmd = '0;
        cmd.kind    = KIND_WINDOW;
        cmd.y_first = row;
        cmd.x_final = 8'(SCREEN - 1);
        cmd.y_final = row + 8'(GH - 1);
        batch.push_back(cmd);
        cmd = '0;
        cmd.kind       = KIND_PIXELS;
        cmd.colour     = bg;
        cmd.run_length = 11'(SCREEN * GH);
        batch.push_back(cmd);
        next_start = int'(start_line) + GH;
        if (next_start >= SCREEN) next_start = 0;
        start_line = 7'(next_start);
        cmd = '0;
        cmd.kind       = KIND_START;
        cmd.start_line = start_line;
        batch.push_back(cmd);
      end
      foreach (batch[i]) begin
        cmd = batch[i];
        cmd.last = (i == batch.size() - 1);
        pending_cmds.push_back(cmd);
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [71:0] data, logic last);
      console_cmd_t want;
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0h data %0h",
                 $time, kind, data);
        failures++;
        return;
      end
      want = pending_cmds.pop_front();
      compare_field("kind",       16'(want.kind),       16'(kind));
      compare_field("x_first",    16'(want.x_first),    16'(data[7:0]));
      compare_field("y_first",    16'(want.y_first),    16'(data[15:8]));
      compare_field("x_final",    16'(want.x_final),    16'(data[23:16]));
      compare_field("y_final",    16'(want.y_final),    16'(data[31:24]));
      compare_field("colour",     want.colour,          data[47:32]);
      compare_field("run_length", 16'(want.run_length), 16'(data[58:48]));
      compare_field("start_line", 16'(want.start_line), 16'(data[65:59]));
      compare_field("last",       16'(want.last),       16'(last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  console_scoreboard sb;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_request = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;
  int  cycle_count = 0;

  text_console_renderer_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** text_console_renderer_top: FAILED **");
      $finish;
    end
  end

  // Receiver: check each taken result, then choose tready for the next edge
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      if (hold_request != hold_seen) begin
        hold_seen = hold_request;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_request(logic op, logic [7:0] code, logic [8:0] addr,
                              logic [7:0] fbyte);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'b0, fbyte, addr, code};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(op, code, addr, fbyte);
  endtask

  // Mostly printable text from the loaded glyphs, line breaks, font writes, stray codes
  task automatic send_random_request();
    int          pick;
    logic [7:0]  code;
    logic [8:0]  addr;
    pick = $urandom_range(99);
    code = 8'($urandom);
    addr = 9'($urandom);
    if (pick < 15) begin
      addr = ($urandom_range(19) == 0) ? 9'($urandom_range(511, FONT_DEPTH))
                                       : 9'($urandom_range(FONT_DEPTH - 1));
      send_request(OP_FONT, code, addr, 8'($urandom));
    end else begin
      if (pick < 23) begin
        code = CHAR_CR;
      end else if (pick < 33) begin
        code = CHAR_LF;
      end else if (pick < 43) begin
        if (code >= CHAR_FIRST && code <= CHAR_LAST) code = code | 8'h80;
        if (code == CHAR_CR || code == CHAR_LF) code = 8'h00;
      end else if ($urandom_range(9) == 0) begin
        code = CHAR_LAST;
      end else begin
        code = 8'($urandom_range(int'(CHAR_FIRST) + LOADED_GLYPHS - 1, int'(CHAR_FIRST)));
      end
      send_request(OP_PRINT, code, addr, 8'($urandom));
    end
  endtask

  // Drop valid, let every expected result arrive and the sequencer go quiet
  task automatic drain_requests();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_cmds.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_colours(logic [15:0] fg, logic [15:0] bg);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FOREGROUND;
    cfg_data  <= fg;
    @(posedge clk);
    sb.set_colour(REG_FOREGROUND, fg);
    cfg_index <= REG_BACKGROUND;
    cfg_data  <= bg;
    @(posedge clk);
    sb.set_colour(REG_BACKGROUND, bg);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  initial begin
    logic [15:0] fg_pick;
    logic [15:0] bg_pick;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_idling(22, 51);

    // Load the low glyphs and the last one; prints only ever use these
    for (int a = 0; a < LOADED_GLYPHS * GW; a++)
      send_request(OP_FONT, 8'($urandom), 9'(a), 8'($urandom));
    for (int a = (GLYPH_COUNT - 1) * GW; a < FONT_DEPTH; a++)
      send_request(OP_FONT, 8'($urandom), 9'(a), 8'($urandom));

    // Directed: ignored addresses, byte extremes, clamping, CR and LF
    send_request(OP_FONT, 8'h00, 9'd480, 8'hAA);
    send_request(OP_FONT, 8'hFF, 9'd511, 8'h55);
    send_request(OP_FONT, 8'h00, 9'd165, 8'hFF);
    send_request(OP_FONT, 8'h00, 9'd166, 8'h00);
    send_request(OP_PRINT, 8'h41, 9'h1FF, 8'hFF);
    send_request(OP_PRINT, CHAR_FIRST, '0, '0);
    send_request(OP_PRINT, CHAR_LAST, '0, '0);
    send_request(OP_PRINT, 8'h1F, '0, '0);
    send_request(OP_PRINT, 8'h00, '0, '0);
    send_request(OP_PRINT, 8'h80, '0, '0);
    send_request(OP_PRINT, 8'hFF, '0, '0);
    send_request(OP_PRINT, CHAR_CR, '0, '0);
    send_request(OP_PRINT, CHAR_LF, '0, '0);
    send_request(OP_PRINT, CHAR_CR, '0, '0);
    send_request(OP_PRINT, 8'h41, '0, '0);
    send_request(OP_PRINT, CHAR_LF, '0, '0);
    send_request(OP_PRINT, CHAR_LF, '0, '0);
    drain_requests();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          fg_pick = 16'h0000;
          bg_pick = 16'hFFFF;
        end
        3: begin
          fg_pick = FOREGROUND_RESET;
          bg_pick = BACKGROUND_RESET;
        end
        default: begin
          fg_pick = 16'($urandom);
          bg_pick = 16'($urandom);
        end
      endcase
      write_colours(fg_pick, bg_pick);
      if (phase < 2) set_idling(22, 51);
      else if (phase < 4) set_idling(51, 22);
      else set_idling(0, 0);
      // Hold the output back for a long stretch so the input stalls
      if (phase == 4) hold_request <= ~hold_request;
      for (int n = 0; n < 52; n++) send_random_request();
      drain_requests();
    end

    repeat (50) @(posedge clk);
    if (sb.failures == 0)
      $display("** text_console_renderer_top: PASSED **");
    else
      $display("** text_console_renderer_top: FAILED **");
    $finish;
  end

endmodule

### sim.f
rtl/core/tcr_pkg.sv
rtl/core/tcr_ram.sv
rtl/core/text_console_renderer_top.sv
tb/sv/text_console_renderer_top_tb.sv
